FILE: design/indent_aware_tokenizer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indentation-aware tokenizer
// Clocked implication forms shared by the checker.
// ---------------------------------------------------------------------------
`ifndef INDENT_AWARE_TOKENIZER_MACROS_SVH
`define INDENT_AWARE_TOKENIZER_MACROS_SVH

// same-cycle implication, reset masks the check
`define IAT_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("tokenizer assertion failed");

// next-cycle implication, reset masks the check
`define IAT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("tokenizer assertion failed");

`endif

FILE: design/iat_pkg.sv
// ---------------------------------------------------------------------------
// iat_pkg
// Types, token codes, character constants and keyword tables of the tokenizer.
// ---------------------------------------------------------------------------
package iat_pkg;

	// token kinds
	localparam logic [4:0] K_AT        = 5'd4;
	localparam logic [4:0] K_IDENT     = 5'd5;
	localparam logic [4:0] K_NUMBER    = 5'd6;
	localparam logic [4:0] K_COLON     = 5'd7;
	localparam logic [4:0] K_ARROW     = 5'd8;
	localparam logic [4:0] K_LBRACKET  = 5'd9;
	localparam logic [4:0] K_RBRACKET  = 5'd10;
	localparam logic [4:0] K_LPAREN    = 5'd11;
	localparam logic [4:0] K_RPAREN    = 5'd12;
	localparam logic [4:0] K_COMMA     = 5'd13;
	localparam logic [4:0] K_EQUAL     = 5'd14;
	localparam logic [4:0] K_PLUS      = 5'd15;
	localparam logic [4:0] K_STAR      = 5'd16;
	localparam logic [4:0] K_DOT       = 5'd17;
	localparam logic [4:0] K_NEWLINE   = 5'd18;
	localparam logic [4:0] K_INDENT    = 5'd19;
	localparam logic [4:0] K_DEDENT    = 5'd20;
	localparam logic [4:0] K_EOF       = 5'd21;
	localparam logic [4:0] K_BADINDENT = 5'd22;
	localparam logic [4:0] K_BADCHAR   = 5'd23;
	localparam logic [4:0] K_OVERFLOW  = 5'd24;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_DOT   = 8'h2e;

	localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;

	typedef enum logic [2:0] {
		M_START, M_SKIP, M_MID, M_IDENT, M_INT, M_FRAC, M_COMMENT
	} mode_t;

	typedef enum logic [1:0] {
		P_NONE, P_CR, P_MINUS
	} pend_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_LOADB, OP_LOADCR, OP_SETCR, OP_CLRPEND, OP_MINUS,
		OP_CONTENT, OP_PUSH, OP_OVERFLOW, OP_POP, OP_BADIND, OP_DISPATCH,
		OP_FLUSH, OP_ENDLINE, OP_EOS_BAD, OP_EOS_POP, OP_EOF, OP_RELEASE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic  hold_err;
		pend_t pend;
		logic  b_cr;
		logic  b_lf;
		logic  cont_indent;
		logic  cont_dispatch;
		logic  flushable;
		logic  partial;
		logic  gt;
		logic  lt;
		logic  cnt_gt1;
		logic  full;
		logic  slot_free;
		logic  hold_v;
	} stat_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// single-character punctuation; bit 5 flags a match
	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		case (c)
			8'h40:   return {1'b1, K_AT};
			8'h3a:   return {1'b1, K_COLON};
			8'h5b:   return {1'b1, K_LBRACKET};
			8'h5d:   return {1'b1, K_RBRACKET};
			8'h28:   return {1'b1, K_LPAREN};
			8'h29:   return {1'b1, K_RPAREN};
			8'h2c:   return {1'b1, K_COMMA};
			8'h3d:   return {1'b1, K_EQUAL};
			8'h2b:   return {1'b1, K_PLUS};
			8'h2a:   return {1'b1, K_STAR};
			8'h2e:   return {1'b1, K_DOT};
			default: return 6'd0;
		endcase
	endfunction

	// keyword lengths: def, return, if, else
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		case (k)
			2'd0:    return 3'd3;
			2'd1:    return 3'd6;
			2'd2:    return 3'd2;
			default: return 3'd4;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [47:0] s;
		case (k)
			2'd0:    s = {24'd0, "fed"};
			2'd1:    s = "nruter";
			2'd2:    s = {32'd0, "fi"};
			default: s = {16'd0, "esle"};
		endcase
		case (i)
			3'd0:    return s[7:0];
			3'd1:    return s[15:8];
			3'd2:    return s[23:16];
			3'd3:    return s[31:24];
			3'd4:    return s[39:32];
			3'd5:    return s[47:40];
			default: return 8'd0;
		endcase
	endfunction

endpackage

FILE: design/iat_dpath.sv
// ---------------------------------------------------------------------------
// iat_dpath
// Tokenizer datapath: scan state, indentation stack memory, token buffer and
// output register. Executes one controller command per cycle.
// ---------------------------------------------------------------------------
module iat_dpath #(
	parameter int STACK_DEPTH = 16,
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iat_pkg::cmd_t          cmd,
	output iat_pkg::stat_t         st,
	input  logic [7:0]             in_byte,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [4:0]             out_kind,
	output logic [LINE_BITS-1:0]   out_line,
	output logic [COLUMN_BITS-1:0] out_col,
	output logic [COLUMN_BITS-1:0] out_len,
	output logic                   out_last
);
	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

	// scan state
	iat_pkg::mode_t mode_q;
	iat_pkg::pend_t pend_q;
	logic err_q;
	logic [3:0] tw_q;
	logic [7:0] b_q, c_q;
	logic [COLUMN_BITS-1:0] sum_q, col_q, start_q, len_q, top_q, rd_q;
	logic [LINE_BITS-1:0] line_q;
	logic [3:0] kw_q;
	logic [CW-1:0] cnt_q;
	logic [COLUMN_BITS-1:0] stack_mem [STACK_DEPTH];

	// token buffer and output register
	logic hv_q;
	logic [4:0] hk_q;
	logic [LINE_BITS-1:0] hl_q;
	logic [COLUMN_BITS-1:0] hc_q, hn_q;
	logic ov_q, olast_q;
	logic [4:0] ok_q;
	logic [LINE_BITS-1:0] ol_q;
	logic [COLUMN_BITS-1:0] oc_q, on_q;

	function automatic logic [COLUMN_BITS-1:0] sat_inc(input logic [COLUMN_BITS-1:0] a);
		return (a == COL_MAX) ? a : a + 1'b1;
	endfunction

	function automatic logic [COLUMN_BITS-1:0] sat_addw(input logic [COLUMN_BITS-1:0] a,
		input logic [3:0] w);
		logic [COLUMN_BITS:0] s;
		s = {1'b0, a} + {{(COLUMN_BITS-3){1'b0}}, w};
		return s[COLUMN_BITS] ? COL_MAX : s[COLUMN_BITS-1:0];
	endfunction

	// kind of a finished identifier or number
	logic [4:0] flush_kind;
	always_comb begin
		flush_kind = iat_pkg::K_NUMBER;
		if (mode_q == iat_pkg::M_IDENT) begin
			flush_kind = iat_pkg::K_IDENT;
			for (int k = 0; k < 4; k++)
				if (kw_q[k] && len_q == COLUMN_BITS'(iat_pkg::kw_len(2'(k))))
					flush_kind = 5'(k);
		end
	end

	// keyword candidates after one more identifier byte
	logic [3:0] kw_ext;
	always_comb begin
		for (int k = 0; k < 4; k++)
			kw_ext[k] = kw_q[k] && (len_q < COLUMN_BITS'(iat_pkg::kw_len(2'(k))))
				&& (iat_pkg::kw_char(2'(k), len_q[2:0]) == c_q);
	end

	// character classes
	logic c_alpha, c_digit, c_blank;
	logic [5:0] c_punct;
	assign c_alpha = iat_pkg::is_alpha(c_q);
	assign c_digit = iat_pkg::is_digit(c_q);
	assign c_blank = (c_q == iat_pkg::CH_SPACE) || (c_q == iat_pkg::CH_TAB);
	assign c_punct = iat_pkg::punct_kind(c_q);

	// token produced by this cycle's command
	logic e_v;
	logic [4:0] e_kind;
	logic [COLUMN_BITS-1:0] e_col, e_len;
	always_comb begin
		e_v = 1'b0;
		e_kind = iat_pkg::K_EOF;
		e_col = COLUMN_BITS'(1);
		e_len = '0;
		case (cmd.op)
			iat_pkg::OP_MINUS: begin
				e_v = 1'b1;
				e_col = start_q;
				if (b_q == iat_pkg::CH_GT) begin
					e_kind = iat_pkg::K_ARROW;
					e_len = COLUMN_BITS'(2);
				end else begin
					e_kind = iat_pkg::K_BADCHAR;
					e_len = COLUMN_BITS'(1);
				end
			end
			iat_pkg::OP_CONTENT, iat_pkg::OP_FLUSH: begin
				e_v = (cmd.op == iat_pkg::OP_FLUSH) || st.flushable && !(
					(mode_q == iat_pkg::M_IDENT && (c_alpha || c_digit)) ||
					(mode_q == iat_pkg::M_INT && (c_digit || c_q == iat_pkg::CH_DOT)) ||
					(mode_q == iat_pkg::M_FRAC && c_digit));
				e_kind = flush_kind;
				e_col = start_q;
				e_len = len_q;
			end
			iat_pkg::OP_PUSH: begin
				e_v = 1'b1;
				e_kind = iat_pkg::K_INDENT;
			end
			iat_pkg::OP_OVERFLOW: begin
				e_v = 1'b1;
				e_kind = iat_pkg::K_OVERFLOW;
				e_col = col_q;
			end
			iat_pkg::OP_POP, iat_pkg::OP_EOS_POP: begin
				e_v = 1'b1;
				e_kind = iat_pkg::K_DEDENT;
			end
			iat_pkg::OP_BADIND: begin
				e_v = 1'b1;
				e_kind = iat_pkg::K_BADINDENT;
				e_col = col_q;
			end
			iat_pkg::OP_DISPATCH: begin
				e_col = col_q;
				e_len = COLUMN_BITS'(1);
				if (!c_blank && c_q != iat_pkg::CH_HASH && !c_alpha && !c_digit
						&& c_q != iat_pkg::CH_MINUS) begin
					e_v = 1'b1;
					e_kind = c_punct[5] ? c_punct[4:0] : iat_pkg::K_BADCHAR;
				end
			end
			iat_pkg::OP_ENDLINE: begin
				e_v = (mode_q != iat_pkg::M_START) && (mode_q != iat_pkg::M_SKIP);
				e_kind = iat_pkg::K_NEWLINE;
				e_col = sat_inc(col_q);
			end
			iat_pkg::OP_EOS_BAD: begin
				e_v = 1'b1;
				e_kind = iat_pkg::K_BADCHAR;
				e_col = start_q;
				e_len = COLUMN_BITS'(1);
			end
			iat_pkg::OP_EOF: begin
				e_v = 1'b1;
			end
			default: begin
				e_v = 1'b0;
			end
		endcase
	end

	// status to the controller
	always_comb begin
		st.hold_err = err_q;
		st.pend = pend_q;
		st.b_cr = (b_q == iat_pkg::CH_CR);
		st.b_lf = (b_q == iat_pkg::CH_LF);
		st.cont_indent = (mode_q == iat_pkg::M_START) && !c_blank && (c_q != iat_pkg::CH_HASH);
		st.cont_dispatch = (mode_q == iat_pkg::M_MID) ||
			(mode_q == iat_pkg::M_IDENT && !c_alpha && !c_digit) ||
			(mode_q == iat_pkg::M_INT && !c_digit && c_q != iat_pkg::CH_DOT) ||
			(mode_q == iat_pkg::M_FRAC && !c_digit);
		st.flushable = (mode_q == iat_pkg::M_IDENT) || (mode_q == iat_pkg::M_INT) ||
			(mode_q == iat_pkg::M_FRAC);
		st.partial = (col_q != '0) || (pend_q == iat_pkg::P_CR);
		st.gt = sum_q > top_q;
		st.lt = sum_q < top_q;
		st.cnt_gt1 = cnt_q > CW'(1);
		st.full = cnt_q >= CW'(STACK_DEPTH);
		st.slot_free = !ov_q || out_ready;
		st.hold_v = hv_q;
	end

	// stack memory: one write port, registered read of the entry under the top
	logic [CW-1:0] below_addr;
	assign below_addr = cnt_q - CW'(2);
	always_ff @(posedge clk) begin
		if (cmd.op == iat_pkg::OP_PUSH)
			stack_mem[cnt_q[IW-1:0]] <= sum_q;
		rd_q <= stack_mem[below_addr[IW-1:0]];
	end

	// scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iat_pkg::M_START;
			pend_q <= iat_pkg::P_NONE;
			err_q <= 1'b0;
			tw_q <= iat_pkg::TAB_WIDTH_RESET;
			cnt_q <= CW'(1);
			top_q <= '0;
			sum_q <= '0;
			line_q <= LINE_BITS'(1);
			col_q <= '0;
			start_q <= '0;
			len_q <= '0;
			kw_q <= 4'hf;
			b_q <= '0;
			c_q <= '0;
		end else begin
			if (cfg_we)
				tw_q <= cfg_data;
			case (cmd.op)
				iat_pkg::OP_LOAD: b_q <= in_byte;
				iat_pkg::OP_LOADB: c_q <= b_q;
				iat_pkg::OP_LOADCR: begin
					c_q <= iat_pkg::CH_CR;
					pend_q <= iat_pkg::P_NONE;
				end
				iat_pkg::OP_SETCR: pend_q <= iat_pkg::P_CR;
				iat_pkg::OP_CLRPEND: pend_q <= iat_pkg::P_NONE;
				iat_pkg::OP_MINUS: begin
					pend_q <= iat_pkg::P_NONE;
					col_q <= sat_inc(col_q);
					if (b_q != iat_pkg::CH_GT)
						err_q <= 1'b1;
				end
				iat_pkg::OP_CONTENT: begin
					col_q <= sat_inc(col_q);
					case (mode_q)
						iat_pkg::M_START: begin
							if (c_q == iat_pkg::CH_SPACE)
								sum_q <= sat_inc(sum_q);
							else if (c_q == iat_pkg::CH_TAB)
								sum_q <= sat_addw(sum_q, tw_q);
							else if (c_q == iat_pkg::CH_HASH)
								mode_q <= iat_pkg::M_SKIP;
						end
						iat_pkg::M_IDENT: begin
							if (c_alpha || c_digit) begin
								kw_q <= kw_ext;
								len_q <= sat_inc(len_q);
							end else
								mode_q <= iat_pkg::M_MID;
						end
						iat_pkg::M_INT: begin
							if (c_digit)
								len_q <= sat_inc(len_q);
							else if (c_q == iat_pkg::CH_DOT) begin
								len_q <= sat_inc(len_q);
								mode_q <= iat_pkg::M_FRAC;
							end else
								mode_q <= iat_pkg::M_MID;
						end
						iat_pkg::M_FRAC: begin
							if (c_digit)
								len_q <= sat_inc(len_q);
							else
								mode_q <= iat_pkg::M_MID;
						end
						default: ;
					endcase
				end
				iat_pkg::OP_PUSH: begin
					top_q <= sum_q;
					cnt_q <= cnt_q + 1'b1;
				end
				iat_pkg::OP_OVERFLOW, iat_pkg::OP_BADIND: err_q <= 1'b1;
				iat_pkg::OP_POP: begin
					cnt_q <= cnt_q - 1'b1;
					top_q <= (cnt_q == CW'(2)) ? '0 : rd_q;
				end
				iat_pkg::OP_DISPATCH: begin
					mode_q <= iat_pkg::M_MID;
					if (c_q == iat_pkg::CH_HASH)
						mode_q <= iat_pkg::M_COMMENT;
					else if (c_alpha) begin
						mode_q <= iat_pkg::M_IDENT;
						start_q <= col_q;
						len_q <= COLUMN_BITS'(1);
						for (int k = 0; k < 4; k++)
							kw_q[k] <= (iat_pkg::kw_char(2'(k), 3'd0) == c_q);
					end else if (c_digit) begin
						mode_q <= iat_pkg::M_INT;
						start_q <= col_q;
						len_q <= COLUMN_BITS'(1);
					end else if (c_q == iat_pkg::CH_MINUS) begin
						pend_q <= iat_pkg::P_MINUS;
						start_q <= col_q;
					end else if (!c_blank && !c_punct[5])
						err_q <= 1'b1;
				end
				iat_pkg::OP_FLUSH: mode_q <= iat_pkg::M_MID;
				iat_pkg::OP_ENDLINE: begin
					if (line_q != LINE_MAX)
						line_q <= line_q + 1'b1;
					col_q <= '0;
					sum_q <= '0;
					mode_q <= iat_pkg::M_START;
				end
				iat_pkg::OP_EOS_BAD: begin
					err_q <= 1'b1;
					pend_q <= iat_pkg::P_NONE;
				end
				iat_pkg::OP_EOS_POP: cnt_q <= cnt_q - 1'b1;
				iat_pkg::OP_EOF: begin
					mode_q <= iat_pkg::M_START;
					pend_q <= iat_pkg::P_NONE;
					err_q <= 1'b0;
					cnt_q <= CW'(1);
					top_q <= '0;
					sum_q <= '0;
					line_q <= LINE_BITS'(1);
					col_q <= '0;
					start_q <= '0;
					len_q <= '0;
					kw_q <= 4'hf;
				end
				default: ;
			endcase
		end
	end

	// token buffer: the newest token waits until it is known whether it is the last
	logic push_out;
	assign push_out = (e_v && hv_q) || (cmd.op == iat_pkg::OP_RELEASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (push_out)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			if (e_v)
				hv_q <= 1'b1;
			else if (cmd.op == iat_pkg::OP_RELEASE)
				hv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			ok_q <= hk_q;
			ol_q <= hl_q;
			oc_q <= hc_q;
			on_q <= hn_q;
			olast_q <= (cmd.op == iat_pkg::OP_RELEASE);
		end
		if (e_v) begin
			hk_q <= e_kind;
			hl_q <= line_q;
			hc_q <= e_col;
			hn_q <= e_len;
		end
	end

	assign out_valid = ov_q;
	assign out_kind = ok_q;
	assign out_line = ol_q;
	assign out_col = oc_q;
	assign out_len = on_q;
	assign out_last = olast_q;

endmodule

FILE: design/iat_ctrl.sv
// ---------------------------------------------------------------------------
// iat_ctrl
// Tokenizer sequencer: steps one input word through pending-character,
// content, indentation, line-end and end-of-source phases.
// ---------------------------------------------------------------------------
module iat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_eos,
	output logic           in_ready,
	input  iat_pkg::stat_t st,
	output iat_pkg::cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_PEND, S_BYTE, S_CONTENT, S_INDENT, S_DEDENT, S_DWAIT,
		S_DISPATCH, S_ENDLINE, S_NEXT, S_FINISH, S_EOS, S_EOSD
	} state_t;

	state_t state_q, nxt;
	logic then_q, nthen;
	logic eos_q, neos;

	assign in_ready = (state_q == S_IDLE);

	// command and next state
	always_comb begin
		cmd.op = iat_pkg::OP_NONE;
		nxt = state_q;
		nthen = then_q;
		neos = eos_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = iat_pkg::OP_LOAD;
					neos = in_eos;
					nthen = 1'b0;
					nxt = in_eos ? S_EOS : (st.hold_err ? S_IDLE : S_PEND);
				end
			end
			S_PEND: begin
				if (st.slot_free) begin
					if (st.pend == iat_pkg::P_MINUS) begin
						cmd.op = iat_pkg::OP_MINUS;
						nxt = S_FINISH;
					end else if (st.pend == iat_pkg::P_CR) begin
						if (st.b_lf) begin
							cmd.op = iat_pkg::OP_CLRPEND;
							nxt = S_ENDLINE;
						end else begin
							cmd.op = iat_pkg::OP_LOADCR;
							nthen = 1'b1;
							nxt = S_CONTENT;
						end
					end else
						nxt = S_BYTE;
				end
			end
			S_BYTE: begin
				if (st.b_cr) begin
					cmd.op = iat_pkg::OP_SETCR;
					nxt = S_FINISH;
				end else if (st.b_lf)
					nxt = S_ENDLINE;
				else begin
					cmd.op = iat_pkg::OP_LOADB;
					nxt = S_CONTENT;
				end
			end
			S_CONTENT: begin
				if (st.slot_free) begin
					cmd.op = iat_pkg::OP_CONTENT;
					nxt = st.cont_indent ? S_INDENT : (st.cont_dispatch ? S_DISPATCH : S_NEXT);
				end
			end
			S_INDENT, S_DEDENT: begin
				if (st.slot_free) begin
					if (state_q == S_INDENT && st.gt) begin
						cmd.op = st.full ? iat_pkg::OP_OVERFLOW : iat_pkg::OP_PUSH;
						nxt = st.full ? S_NEXT : S_DISPATCH;
					end else if (st.cnt_gt1 && st.lt) begin
						cmd.op = iat_pkg::OP_POP;
						nxt = S_DWAIT;
					end else if (st.gt || st.lt) begin
						cmd.op = iat_pkg::OP_BADIND;
						nxt = S_NEXT;
					end else begin
						cmd.op = iat_pkg::OP_DISPATCH;
						nxt = S_NEXT;
					end
				end
			end
			// wait state: lets the registered stack read catch up with the new top
			S_DWAIT: nxt = S_DEDENT;
			S_DISPATCH: begin
				if (st.slot_free) begin
					cmd.op = iat_pkg::OP_DISPATCH;
					nxt = S_NEXT;
				end
			end
			S_ENDLINE: begin
				if (st.slot_free) begin
					if (st.flushable)
						cmd.op = iat_pkg::OP_FLUSH;
					else begin
						cmd.op = iat_pkg::OP_ENDLINE;
						nxt = eos_q ? S_EOSD : S_NEXT;
					end
				end
			end
			S_NEXT: begin
				nthen = 1'b0;
				nxt = (then_q && !st.hold_err) ? S_BYTE : S_FINISH;
			end
			S_FINISH: begin
				if (!st.hold_v)
					nxt = S_IDLE;
				else if (st.slot_free) begin
					cmd.op = iat_pkg::OP_RELEASE;
					nxt = S_IDLE;
				end
			end
			S_EOS: begin
				if (st.slot_free) begin
					if (st.hold_err) begin
						cmd.op = iat_pkg::OP_EOF;
						nxt = S_FINISH;
					end else if (st.pend == iat_pkg::P_MINUS)
						cmd.op = iat_pkg::OP_EOS_BAD;
					else if (st.partial) begin
						cmd.op = iat_pkg::OP_CLRPEND;
						nxt = S_ENDLINE;
					end else
						nxt = S_EOSD;
				end
			end
			S_EOSD: begin
				if (st.slot_free) begin
					if (st.cnt_gt1)
						cmd.op = iat_pkg::OP_EOS_POP;
					else begin
						cmd.op = iat_pkg::OP_EOF;
						nxt = S_FINISH;
					end
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			then_q <= 1'b0;
			eos_q <= 1'b0;
		end else begin
			state_q <= nxt;
			then_q <= nthen;
			eos_q <= neos;
		end
	end

endmodule

FILE: design/indent_aware_tokenizer.sv
// ---------------------------------------------------------------------------
// indent_aware_tokenizer
// Indentation-aware lexer: source bytes in, tokens with kind, line, column
// and length out, with Indent and Dedent tokens from a stack of widths.
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: byte; tuser: end of source
// m_*       out  m_tvalid/m_tready  tdata: kind,line,column,length; tlast
// cfg_*     in   cfg_valid/cfg_ready cfg_data: tab width
//
// One input word at a time; a word that arrives after an error is dropped
// unless it ends the source. Each Dedent at a line start waits for a
// registered stack read. Output stalls hold the sequencer; the newest
// token waits in a one-entry buffer so that tlast marks the final token of
// each input word.
// Reset is asynchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module indent_aware_tokenizer #(
	parameter int STACK_DEPTH = 16,
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // byte_req
	input  logic s_tuser,         // end of source
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((5 + LINE_BITS + 2 * COLUMN_BITS + 7) / 8) * 8 - 1:0] m_tdata,
		// token_kind, token_line, token_column, token_length
	output logic m_tlast,         // last_of_run
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [3:0] cfg_data
);
	localparam int OUT_W = ((5 + LINE_BITS + 2 * COLUMN_BITS + 7) / 8) * 8;

	iat_pkg::cmd_t  cmd;
	iat_pkg::stat_t st;
	logic [4:0] kind;
	logic [LINE_BITS-1:0] line;
	logic [COLUMN_BITS-1:0] col, len;

	assign cfg_ready = 1'b1;

	iat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_eos(s_tuser), .in_ready(s_tready),
		.st(st), .cmd(cmd)
	);

	iat_dpath #(
		.STACK_DEPTH(STACK_DEPTH), .COLUMN_BITS(COLUMN_BITS), .LINE_BITS(LINE_BITS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .in_byte(s_tdata),
		.cfg_we(cfg_valid), .cfg_data(cfg_data),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_kind(kind),
		.out_line(line), .out_col(col), .out_len(len), .out_last(m_tlast)
	);

	// pack fields from the lowest bit up
	assign m_tdata = OUT_W'({len, col, line, kind});

endmodule

FILE: design/iat_checker.sv
// ---------------------------------------------------------------------------
// iat_checker
// Port-level checks of the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "indent_aware_tokenizer_macros.svh"

module iat_checker #(
	parameter int OUT_W = 48
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic m_tlast
);
	// stalled output word holds
	`IAT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// end of source always produces output, so the block is busy next cycle
	`IAT_ASSERT_NEXT(a_eos_busy, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready)

	// eof closes its run
	`IAT_ASSERT_SAME(a_eof_last, clk, arst_n, m_tvalid && m_tdata[4:0] == iat_pkg::K_EOF, m_tlast)

	// no token code beyond stack overflow
	`IAT_ASSERT_SAME(a_kind_range, clk, arst_n, m_tvalid, m_tdata[4:0] <= iat_pkg::K_OVERFLOW)

endmodule

bind indent_aware_tokenizer iat_checker #(.OUT_W(OUT_W)) u_iat_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast)
);

FILE: bench/tb_indent_aware_tokenizer.sv
// ---------------------------------------------------------------------------
// tb_indent_aware_tokenizer
// Self-checking bench for the indentation-aware tokenizer. Directed sources
// cover keywords, punctuation, numbers, arrow, CR/LF handling, indent and
// dedent runs, stack overflow and bad characters. Random sources follow.
// A local lexer predicts every token, and a monitor checks each output word
// in order against it, under several idle and stall mixes.
// ---------------------------------------------------------------------------
module tb_indent_aware_tokenizer;

	localparam int DEPTH    = 16;
	localparam int COL_MAX  = 4095;
	localparam int LINE_MAX = 65535;
	localparam int WD_LIMIT = 20000;
	localparam int SETTLE   = 64;

	typedef struct {
		logic [4:0]  kind;
		logic [15:0] line;
		logic [11:0] col;
		logic [11:0] len;
		logic        last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_data = 4'd0;

	indent_aware_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected tokens and lexer shadow state
	token_t token_q[$];
	int     errors = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     words_sent = 0;

	int     tab_w;
	iat_pkg::mode_t mode;
	iat_pkg::pend_t pend;
	int     stack_w[DEPTH];
	int     depth_cnt;
	int     indent_w;
	int     line_no;
	int     col_cnt;
	int     tok_start;
	int     lex_cnt;
	logic [3:0] kw_live;
	logic   err_hold;

	string kw_text[4] = '{"def", "return", "if", "else"};

	function automatic int sat(input int a, input int b);
		return (a + b > COL_MAX) ? COL_MAX : a + b;
	endfunction

	function automatic logic alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == iat_pkg::CH_UNDER;
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] punct_code(input logic [7:0] c);
		case (c)
			"@": return {1'b1, iat_pkg::K_AT};
			":": return {1'b1, iat_pkg::K_COLON};
			"[": return {1'b1, iat_pkg::K_LBRACKET};
			"]": return {1'b1, iat_pkg::K_RBRACKET};
			"(": return {1'b1, iat_pkg::K_LPAREN};
			")": return {1'b1, iat_pkg::K_RPAREN};
			",": return {1'b1, iat_pkg::K_COMMA};
			"=": return {1'b1, iat_pkg::K_EQUAL};
			"+": return {1'b1, iat_pkg::K_PLUS};
			"*": return {1'b1, iat_pkg::K_STAR};
			".": return {1'b1, iat_pkg::K_DOT};
			default: return 6'd0;
		endcase
	endfunction

	function automatic void put_tok(input logic [4:0] k, input int c, input int n);
		token_t t;
		t = '{k, line_no[15:0], c[11:0], n[11:0], 1'b0};
		token_q = {token_q, t};
	endfunction

	function automatic void raise_err(input logic [4:0] k, input int c, input int n);
		put_tok(k, c, n);
		err_hold = 1'b1;
	endfunction

	function automatic void clear_lexer();
		mode = iat_pkg::M_START;
		foreach (stack_w[i]) stack_w[i] = 0;
		depth_cnt = 1;
		indent_w = 0;
		line_no = 1;
		col_cnt = 0;
		tok_start = 0;
		lex_cnt = 0;
		kw_live = 4'hf;
		pend = iat_pkg::P_NONE;
		err_hold = 1'b0;
	endfunction

	function automatic void grow_ident(input logic [7:0] c);
		for (int k = 0; k < 4; k++)
			if (!(lex_cnt < kw_text[k].len() && kw_text[k][lex_cnt] == c))
				kw_live[k] = 1'b0;
		lex_cnt = sat(lex_cnt, 1);
	endfunction

	function automatic void flush_tok();
		logic [4:0] k = iat_pkg::K_NUMBER;
		if (mode == iat_pkg::M_IDENT) begin
			k = iat_pkg::K_IDENT;
			for (int i = 0; i < 4; i++)
				if (kw_live[i] && lex_cnt == kw_text[i].len())
					k = i[4:0];
		end
		put_tok(k, tok_start, lex_cnt);
		mode = iat_pkg::M_MID;
	endfunction

	function automatic void start_token(input logic [7:0] c, input int c_col);
		logic [5:0] pk;
		if (c == iat_pkg::CH_SPACE || c == iat_pkg::CH_TAB)
			return;
		if (c == iat_pkg::CH_HASH) begin
			mode = iat_pkg::M_COMMENT;
		end else if (alpha(c)) begin
			mode = iat_pkg::M_IDENT;
			tok_start = c_col;
			lex_cnt = 0;
			kw_live = 4'hf;
			grow_ident(c);
		end else if (digit(c)) begin
			mode = iat_pkg::M_INT;
			tok_start = c_col;
			lex_cnt = 1;
		end else if (c == iat_pkg::CH_MINUS) begin
			pend = iat_pkg::P_MINUS;
			tok_start = c_col;
		end else begin
			pk = punct_code(c);
			if (pk[5])
				put_tok(pk[4:0], c_col, 1);
			else
				raise_err(iat_pkg::K_BADCHAR, c_col, 1);
		end
	endfunction

	// compare line width with the open levels
	function automatic logic indent_ok(input int c_col);
		int top = stack_w[depth_cnt - 1];
		if (indent_w > top) begin
			if (depth_cnt >= DEPTH) begin
				raise_err(iat_pkg::K_OVERFLOW, c_col, 0);
				return 1'b0;
			end
			stack_w[depth_cnt] = indent_w;
			depth_cnt++;
			put_tok(iat_pkg::K_INDENT, 1, 0);
			return 1'b1;
		end
		while (depth_cnt > 1 && indent_w < top) begin
			depth_cnt--;
			top = stack_w[depth_cnt - 1];
			put_tok(iat_pkg::K_DEDENT, 1, 0);
		end
		if (indent_w != top) begin
			raise_err(iat_pkg::K_BADINDENT, c_col, 0);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		int c_col = sat(col_cnt, 1);
		col_cnt = c_col;
		case (mode)
			iat_pkg::M_START: begin
				if (c == iat_pkg::CH_SPACE) indent_w = sat(indent_w, 1);
				else if (c == iat_pkg::CH_TAB) indent_w = sat(indent_w, tab_w);
				else if (c == iat_pkg::CH_HASH) mode = iat_pkg::M_SKIP;
				else begin
					if (!indent_ok(c_col))
						return;
					mode = iat_pkg::M_MID;
					start_token(c, c_col);
				end
			end
			iat_pkg::M_MID: start_token(c, c_col);
			iat_pkg::M_IDENT: begin
				if (alpha(c) || digit(c)) grow_ident(c);
				else begin
					flush_tok();
					start_token(c, c_col);
				end
			end
			iat_pkg::M_INT: begin
				if (digit(c)) lex_cnt = sat(lex_cnt, 1);
				else if (c == iat_pkg::CH_DOT) begin
					lex_cnt = sat(lex_cnt, 1);
					mode = iat_pkg::M_FRAC;
				end else begin
					flush_tok();
					start_token(c, c_col);
				end
			end
			iat_pkg::M_FRAC: begin
				if (digit(c)) lex_cnt = sat(lex_cnt, 1);
				else begin
					flush_tok();
					start_token(c, c_col);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void close_line();
		if (mode != iat_pkg::M_START && mode != iat_pkg::M_SKIP) begin
			if (mode == iat_pkg::M_IDENT || mode == iat_pkg::M_INT || mode == iat_pkg::M_FRAC)
				flush_tok();
			put_tok(iat_pkg::K_NEWLINE, sat(col_cnt, 1), 0);
		end
		if (line_no < LINE_MAX)
			line_no++;
		col_cnt = 0;
		indent_w = 0;
		mode = iat_pkg::M_START;
	endfunction

	function automatic void lex_byte(input logic [7:0] b);
		if (pend == iat_pkg::P_MINUS) begin
			pend = iat_pkg::P_NONE;
			col_cnt = sat(col_cnt, 1);
			if (b == iat_pkg::CH_GT) put_tok(iat_pkg::K_ARROW, tok_start, 2);
			else raise_err(iat_pkg::K_BADCHAR, tok_start, 1);
			return;
		end
		if (pend == iat_pkg::P_CR) begin
			pend = iat_pkg::P_NONE;
			if (b == iat_pkg::CH_LF) begin
				close_line();
				return;
			end
			scan_char(iat_pkg::CH_CR);
			if (err_hold)
				return;
		end
		if (b == iat_pkg::CH_CR) pend = iat_pkg::P_CR;
		else if (b == iat_pkg::CH_LF) close_line();
		else scan_char(b);
	endfunction

	function automatic void lex_end();
		logic partial;
		if (!err_hold) begin
			if (pend == iat_pkg::P_MINUS) begin
				pend = iat_pkg::P_NONE;
				raise_err(iat_pkg::K_BADCHAR, tok_start, 1);
			end else begin
				partial = col_cnt > 0 || pend == iat_pkg::P_CR;
				pend = iat_pkg::P_NONE;
				if (partial)
					close_line();
			end
			if (!err_hold)
				while (depth_cnt > 1) begin
					depth_cnt--;
					put_tok(iat_pkg::K_DEDENT, 1, 0);
				end
		end
		put_tok(iat_pkg::K_EOF, 1, 0);
		clear_lexer();
	endfunction

	// predict tokens for one accepted word, tag the final one
	function automatic void predict_word(input logic eos, input logic [7:0] b);
		int n0 = token_q.size();
		if (eos) lex_end();
		else if (!err_hold) lex_byte(b);
		if (token_q.size() > n0)
			token_q[token_q.size() - 1].last = 1'b1;
	endfunction

	// receiver backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// output monitor
	always @(posedge clk) begin
		token_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				$error("unexpected token word %h", m_tdata);
				errors++;
			end else begin
				e = token_q.pop_front();
				if (m_tdata[4:0] !== e.kind) begin
					$error("token_kind exp %0d got %0d", e.kind, m_tdata[4:0]);
					errors++;
				end
				if (m_tdata[20:5] !== e.line) begin
					$error("token_line exp %0d got %0d", e.line, m_tdata[20:5]);
					errors++;
				end
				if (m_tdata[32:21] !== e.col) begin
					$error("token_column exp %0d got %0d", e.col, m_tdata[32:21]);
					errors++;
				end
				if (m_tdata[44:33] !== e.len) begin
					$error("token_length exp %0d got %0d", e.len, m_tdata[44:33]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_of_run exp %0d got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WD_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// send one word, with random idle cycles ahead of it
	task automatic send_word(input logic eos, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= eos;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		predict_word(eos, b);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(1'b0, s[i]);
	endtask

	task automatic send_eos();
		send_word(1'b1, 8'($urandom));
	endtask

	// hold the sender until every expected token is out, then let it settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_tab(input logic [3:0] w);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		tab_w = w;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_tokens();
		send_text("def f(x1, _y):\n  return [a]*2.5+@b.c=3.\r\n");
		send_text("if x -> 12:\n\telse\n");
		send_eos();
	endtask

	task automatic test_layout();
		send_text("a\n\tb\n\t\tc\n   \n  # note\r\n\t d\r\n");
		send_text("\tx # tail\n e\n");
		send_eos();
		send_text("p\n\tq");
		send_eos();
		send_text("  \r");
		send_eos();
	endtask

	task automatic test_errors();
		send_text("a-b\nc\n");
		send_eos();
		send_text("x\ry\n");
		send_eos();
		send_text("#\r!\nz-");
		send_eos();
		send_text("q -");
		send_eos();
		send_word(1'b0, 8'hff);
		send_text("ab");
		send_eos();
	endtask

	// strictly growing widths from tabs and one space, one level too many
	task automatic test_overflow();
		string s = "a\n";
		for (int d = 1; d <= DEPTH; d++) begin
			for (int i = 0; i < d / 2; i++) s = {s, "\t"};
			if (d % 2 != 0) s = {s, " "};
			s = {s, "k\n"};
		end
		send_text(s);
		send_eos();
	endtask

	// random sources: mostly well-formed lines, some noise
	task automatic test_random(input int n_words);
		string vocab[12] = '{"def", "return", "if", "else", "x_1", "12", "3.25", "->",
			"(a, b)", "[i]", "@m*n+k", "v = w."};
		int lvl;
		int stop = words_sent + n_words;
		while (words_sent < stop) begin
			lvl = 0;
			repeat ($urandom_range(8, 1)) begin
				lvl = $urandom_range(lvl + 1, 0);
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(6)) send_text(" ");
				end else begin
					for (int i = 0; i < lvl; i++)
						send_text($urandom_range(1) ? "\t" : " ");
				end
				case ($urandom_range(9))
					0: send_text("# c");
					1: ;
					2: send_word(1'b0, 8'($urandom));
					default: repeat ($urandom_range(4, 1)) begin
						send_text(vocab[$urandom_range(11)]);
						if ($urandom_range(1)) send_text(" ");
					end
				endcase
				send_text($urandom_range(3) == 0 ? "\r\n" : "\n");
			end
			send_eos();
		end
	endtask

	initial begin
		tab_w = iat_pkg::TAB_WIDTH_RESET;
		clear_lexer();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 0;  recv_stall_pct = 0;  test_tokens();
		send_idle_pct = 69; recv_stall_pct = 0;  test_layout();
		set_tab(4'd15);
		send_idle_pct = 0;  recv_stall_pct = 69; test_errors();
		test_overflow();
		set_tab(4'd0);
		send_idle_pct = 29; recv_stall_pct = 29; test_random(25);

		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/iat_pkg.sv
design/iat_dpath.sv
design/iat_ctrl.sv
design/indent_aware_tokenizer.sv
design/iat_checker.sv
bench/tb_indent_aware_tokenizer.sv
